[hw/rtl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the array deque.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DQ_DEPTH  = 8;
  localparam int DQ_IDX_W  = $clog2(DQ_DEPTH);
  localparam int DQ_CNT_W  = $clog2(DQ_DEPTH + 1);
  localparam int DQ_DATA_W = 32;

  // operation codes
  localparam logic [2:0] OP_INS_REAR  = 3'd0;
  localparam logic [2:0] OP_INS_FRONT = 3'd1;
  localparam logic [2:0] OP_DEL_REAR  = 3'd2;
  localparam logic [2:0] OP_DEL_FRONT = 3'd3;
  localparam logic [2:0] OP_LIST      = 3'd4;

  // status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]                  operation;
    logic signed [DQ_DATA_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic signed [DQ_DATA_W-1:0] data_out;
    logic                        last;
  } out_item_t;

  // storage access, one port, read or write in a cycle
  typedef struct packed {
    logic                 wr_en;
    logic                 rd_en;
    logic [DQ_IDX_W-1:0]  addr;
    logic [DQ_DATA_W-1:0] wdata;
  } mem_req_t;

  // result command from the controller to the output stage
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic       use_rd;
    logic       last;
  } res_cmd_t;

endpackage

[hw/rtl/double_ended_queue_top.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Result path: inserts, refused operations and empty results pass only the
//   output register; deleted and listed values pass the storage read
//   register, then the output register; a listing gives one result per cycle.
// Throughput: inserts 1 transaction/cycle while busy is low; deletes and
//   lists hold busy until their last result is issued (single storage port).
// Reset: synchronous active-low; pointers cleared, slot storage not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_top
  import dq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  // input transaction: accepted when start is high and busy is low
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  // results: one cycle each, marked by out_valid, cannot be stalled
  output logic      out_valid,
  output out_item_t out_item
);

  mem_req_t             mem_req;
  res_cmd_t             res_cmd;
  logic [DQ_DATA_W-1:0] rd_data;

  logic                 out_valid_r;
  out_item_t            out_item_r;

  // controller: pointers, decode and the list walk
  dq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .mem_req (mem_req),
    .res_cmd (res_cmd)
  );

  // slot storage, read data registered inside
  dq_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  // output register: strobe is control, payload is loaded only with a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_cmd.valid) begin
      out_item_r.status   <= res_cmd.status;
      // deleted or listed value comes straight off the storage read port
      out_item_r.data_out <= res_cmd.use_rd ? rd_data : '0;
      out_item_r.last     <= res_cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[hw/rtl/dq_mem.sv]
// ----------------------------------------------------------------------------
// dq_mem
// Slot storage: synchronous single-port memory, registered read data.
// ----------------------------------------------------------------------------
module dq_mem
  import dq_pkg::*;
(
  input  logic                 clk,
  input  mem_req_t             mem_req,
  output logic [DQ_DATA_W-1:0] rd_data
);

  logic [DQ_DATA_W-1:0] mem [DQ_DEPTH];
  logic [DQ_DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.addr] <= mem_req.wdata;
    end
    if (mem_req.rd_en) begin
      rd_data_r <= mem[mem_req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/dq_ctrl.sv]
// ----------------------------------------------------------------------------
// dq_ctrl
// Pointer state, operation decode and list sequencer for the deque.
// ----------------------------------------------------------------------------
module dq_ctrl
  import dq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_item_t in_item,
  output logic     busy,
  output mem_req_t mem_req,
  output res_cmd_t res_cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DEL  = 3'b010,
    ST_LIST = 3'b100
  } state_t;

  localparam logic [DQ_CNT_W-1:0] DEPTH_C = DQ_CNT_W'(DQ_DEPTH);

  state_t              state_r, state_nxt;
  logic [DQ_CNT_W-1:0] rear_r, rear_nxt;     // rear index + 1
  logic [DQ_CNT_W-1:0] front_r, front_nxt;
  logic [DQ_IDX_W-1:0] list_idx_r, list_idx_nxt;
  logic                empty;
  logic                list_last;

  assign empty     = (rear_r == '0) || (front_r >= rear_r);
  assign list_last = ((DQ_CNT_W'(list_idx_r) + 1'b1) == rear_r);
  assign busy      = (state_r != ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    rear_nxt     = rear_r;
    front_nxt    = front_r;
    list_idx_nxt = list_idx_r;
    mem_req      = '0;
    res_cmd      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_item.operation)
            OP_INS_REAR: begin
              res_cmd.valid = 1'b1;
              res_cmd.last  = 1'b1;
              if (rear_r >= DEPTH_C) begin
                res_cmd.status = STS_FULL;
              end else begin
                mem_req.wr_en  = 1'b1;
                mem_req.addr   = rear_r[DQ_IDX_W-1:0];
                mem_req.wdata  = in_item.data_in;
                rear_nxt       = rear_r + 1'b1;
                res_cmd.status = STS_OK;
              end
            end
            OP_INS_FRONT: begin
              res_cmd.valid = 1'b1;
              res_cmd.last  = 1'b1;
              if ((front_r == '0) && (rear_r == '0)) begin
                // both pointers at zero: value lands in slot 0
                mem_req.wr_en  = 1'b1;
                mem_req.addr   = '0;
                mem_req.wdata  = in_item.data_in;
                rear_nxt       = DQ_CNT_W'(1);
                res_cmd.status = STS_OK;
              end else if ((rear_r >= DEPTH_C) || (front_r == '0)) begin
                res_cmd.status = STS_FULL;
              end else begin
                front_nxt      = front_r - 1'b1;
                mem_req.wr_en  = 1'b1;
                mem_req.addr   = front_nxt[DQ_IDX_W-1:0];
                mem_req.wdata  = in_item.data_in;
                res_cmd.status = STS_OK;
              end
            end
            OP_DEL_REAR: begin
              if (empty) begin
                res_cmd.valid  = 1'b1;
                res_cmd.last   = 1'b1;
                res_cmd.status = STS_EMPTY;
              end else begin
                rear_nxt      = rear_r - 1'b1;
                mem_req.rd_en = 1'b1;
                mem_req.addr  = rear_nxt[DQ_IDX_W-1:0];
                state_nxt     = ST_DEL;
              end
            end
            OP_DEL_FRONT: begin
              if (empty) begin
                res_cmd.valid  = 1'b1;
                res_cmd.last   = 1'b1;
                res_cmd.status = STS_EMPTY;
              end else begin
                mem_req.rd_en = 1'b1;
                mem_req.addr  = front_r[DQ_IDX_W-1:0];
                front_nxt     = front_r + 1'b1;
                state_nxt     = ST_DEL;
              end
            end
            OP_LIST: begin
              if (empty) begin
                res_cmd.valid  = 1'b1;
                res_cmd.last   = 1'b1;
                res_cmd.status = STS_EMPTY;
              end else begin
                mem_req.rd_en = 1'b1;
                mem_req.addr  = front_r[DQ_IDX_W-1:0];
                list_idx_nxt  = front_r[DQ_IDX_W-1:0];
                state_nxt     = ST_LIST;
              end
            end
            default: begin
              // unused codes: no result, state kept
            end
          endcase
        end
      end
      ST_DEL: begin
        res_cmd.valid  = 1'b1;
        res_cmd.status = STS_OK;
        res_cmd.use_rd = 1'b1;
        res_cmd.last   = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_LIST: begin
        res_cmd.valid  = 1'b1;
        res_cmd.status = STS_OK;
        res_cmd.use_rd = 1'b1;
        res_cmd.last   = list_last;
        if (list_last) begin
          state_nxt = ST_IDLE;
        end else begin
          mem_req.rd_en = 1'b1;
          mem_req.addr  = list_idx_r + 1'b1;
          list_idx_nxt  = list_idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rear_r  <= '0;
      front_r <= '0;
    end else begin
      state_r <= state_nxt;
      rear_r  <= rear_nxt;
      front_r <= front_nxt;
    end
  end

  always_ff @(posedge clk) begin
    list_idx_r <= list_idx_nxt;
  end

`ifndef SYNTHESIS
  a_front_le_rear: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= rear_r)
    else $error("front index past rear");

  a_rear_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rear_r <= DEPTH_C)
    else $error("rear index beyond storage");

  a_del_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEL) |-> $past(mem_req.rd_en))
    else $error("delete result without a storage read");

  a_write_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> ((state_r == ST_IDLE) && !mem_req.rd_en))
    else $error("storage write outside idle or with a read");

  a_list_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST) |-> (DQ_CNT_W'(list_idx_r) < rear_r))
    else $error("list walk outside stored elements");
`endif

endmodule
